### rtl/aiwd_pkg.sv
// Package for the accelerometer impulse window detector: payload structs,
// register indexes, reset values and width constants. No dependencies.
package aiwd_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_G        = 2'd2;

    localparam logic [21:0] WINDOW_US_RST = 22'd200000;
    localparam logic [39:0] THRESHOLD_RST = 40'd983040000;
    localparam logic [14:0] ONE_G_RST     = 15'd8192;

    localparam int SUM_W = 48;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int PROD_W = 49;     // 17-bit deviation pair times 32-bit dt

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [31:0]        time_us;
    } t_in_item;

    typedef struct packed {
        logic              impulse_pulse;
        logic              impulse_level;
        logic [SUM_W-1:0]  window_sum;
        logic              forced_drop;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [15:0] root;
    } t_sqrt_rsp;

endpackage

### rtl/aiwd_stream_if.sv
// Valid/ready stream interface carrying one payload of a chosen type.
// Depends on nothing; the payload type is set where it is instantiated.
interface aiwd_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/aiwd_isqrt.sv
// Digit-serial floor square root of a 32-bit value, one root bit per cycle.
// Depends on aiwd_pkg for the request and response structs.
module aiwd_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aiwd_pkg::t_sqrt_req i_req,
    output aiwd_pkg::t_sqrt_rsp o_rsp
);
    import aiwd_pkg::*;

    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [31:0] r_rad;
    logic [17:0] r_rem;
    logic [15:0] r_root;
    logic        r_done;

    logic [19:0] w_rem_t;
    logic [19:0] w_trial;
    logic        w_fit;

    assign w_rem_t = {r_rem, r_rad[31:30]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_fit   = w_rem_t >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[29:0], 2'b00};
            r_rem  <= w_fit ? 18'(w_rem_t - w_trial) : w_rem_t[17:0];
            r_root <= {r_root[14:0], w_fit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("square root done without a running iteration");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy && !i_req.start |=> !r_busy)
        else $error("square root started by itself");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("square root busy after done");
endmodule

### rtl/accel_impulse_window_detector_core.sv
// Channel   | dir | payload                                   | accepted when
// i_sample  | in  | accel_x/y/z s16, time_us u32               | valid && ready
// o_result  | out | impulse_pulse, impulse_level, window_sum, forced_drop | valid && ready
// cfg       | in  | i_cfg_we, i_cfg_idx, i_cfg_data             | i_cfg_we
//
// One sample runs through the squares, the digit-serial square root, one ring
// read and one age check per evicted entry, and the trapezoid pass over the
// entries left, one ring read a cycle.
// Reset (synchronous, i_rst_n low) empties the ring and restores registers.
// A result waits in the output register; the next sample is taken meanwhile,
// and only a second finished result stalls on a blocked output.
// Depends on aiwd_pkg, aiwd_stream_if and aiwd_isqrt.
module accel_impulse_window_detector_core #(
    parameter int RING_DEPTH = aiwd_pkg::RING_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    aiwd_stream_if.sink                      i_sample,
    aiwd_stream_if.source                    o_result,
    input  logic                             i_cfg_we,
    input  logic [aiwd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aiwd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import aiwd_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int TW = PROD_W + AW;
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_SQ     = 8'b00000010,
        ST_SQRT   = 8'b00000100,
        ST_EV_RD  = 8'b00001000,
        ST_EV_CHK = 8'b00010000,
        ST_APPEND = 8'b00100000,
        ST_SUM    = 8'b01000000,
        ST_RESULT = 8'b10000000
    } t_state;

    function automatic logic [AW-1:0] f_slot(logic [AW-1:0] h, logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
        return s[AW-1:0];
    endfunction

    t_state      r_state;
    logic [21:0] r_window;
    logic [39:0] r_thresh;
    logic [14:0] r_one_g;

    t_in_item    r_in;
    logic [1:0]  r_sqc;
    logic [31:0] r_sqp;
    logic [31:0] r_acc;
    logic [15:0] r_dev;
    logic        r_forced;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_flag;

    logic [47:0] r_ring [RING_DEPTH];
    logic [47:0] r_rdata;

    logic [CW-1:0] r_rk;
    logic          r_rv;
    logic          r_hp;
    logic [47:0]   r_prev;
    logic [PROD_W-1:0] r_prod;
    logic          r_pv;
    logic [TW-1:0] r_total;

    t_out_item   r_out;
    logic        r_out_valid;

    t_sqrt_req   w_sq_req;
    t_sqrt_rsp   w_sq_rsp;
    logic [15:0] w_abs;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_head_eff;
    logic [CW-1:0] w_count_eff;
    logic [31:0]   w_age;
    logic [SUM_W-1:0] w_sum;
    logic          w_level;
    logic          w_out_load;

    aiwd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sq_req),
        .o_rsp   (w_sq_rsp)
    );

    always_comb begin
        case (r_sqc)
            2'd0:    w_abs = r_in.accel_x[15] ? 16'(~r_in.accel_x + 16'd1) : r_in.accel_x;
            2'd1:    w_abs = r_in.accel_y[15] ? 16'(~r_in.accel_y + 16'd1) : r_in.accel_y;
            default: w_abs = r_in.accel_z[15] ? 16'(~r_in.accel_z + 16'd1) : r_in.accel_z;
        endcase
    end

    assign w_sq_req.start    = (r_state == ST_SQ) && (r_sqc == 2'd3);
    assign w_sq_req.radicand = r_acc + r_sqp;

    assign w_age       = r_in.time_us - r_rdata[47:16];
    assign w_head_eff  = (r_count == DEPTH_C) ? f_slot(r_head, CW'(1)) : r_head;
    assign w_count_eff = (r_count == DEPTH_C) ? CW'(RING_DEPTH - 1) : r_count;
    assign w_raddr     = (r_state == ST_SUM) ? f_slot(r_head, r_rk) : r_head;

    assign w_sum   = (r_total > TW'(SUM_MAX)) ? SUM_MAX : r_total[SUM_W-1:0];
    assign w_level = w_sum >= {8'd0, r_thresh};

    assign w_out_load = (r_state == ST_RESULT) && (!r_out_valid || o_result.ready);

    assign i_sample.ready   = (r_state == ST_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // Ring storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPEND) begin
            r_ring[f_slot(w_head_eff, w_count_eff)] <= {r_in.time_us, r_dev};
        end
        r_rdata <= r_ring[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_US_RST;
            r_thresh <= THRESHOLD_RST;
            r_one_g  <= ONE_G_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_US: r_window <= i_cfg_data[21:0];
                CFG_THRESHOLD: r_thresh <= i_cfg_data[39:0];
                CFG_ONE_G:     r_one_g  <= i_cfg_data[14:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rv        <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_sqc <= 2'd0;
                    if (i_sample.valid) begin
                        r_in    <= i_sample.payload;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sqp <= w_abs * w_abs;
                    r_acc <= (r_sqc == 2'd0) ? 32'd0 : r_acc + r_sqp;
                    r_sqc <= r_sqc + 2'd1;
                    if (r_sqc == 2'd3) r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_forced <= 1'b0;
                    if (w_sq_rsp.done) begin
                        r_dev   <= (w_sq_rsp.root >= {1'b0, r_one_g})
                                 ? 16'(w_sq_rsp.root - {1'b0, r_one_g})
                                 : 16'({1'b0, r_one_g} - w_sq_rsp.root);
                        r_state <= ST_EV_RD;
                    end
                end
                ST_EV_RD: begin
                    r_state <= (r_count == '0) ? ST_APPEND : ST_EV_CHK;
                end
                ST_EV_CHK: begin
                    // drop the oldest entry while it is strictly outside the window
                    if (w_age > {10'd0, r_window}) begin
                        r_head  <= f_slot(r_head, CW'(1));
                        r_count <= r_count - CW'(1);
                        r_state <= ST_EV_RD;
                    end else begin
                        r_state <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    r_forced <= (r_count == DEPTH_C);
                    r_head   <= w_head_eff;
                    r_count  <= w_count_eff + CW'(1);
                    r_rk     <= '0;
                    r_rv     <= 1'b0;
                    r_hp     <= 1'b0;
                    r_pv     <= 1'b0;
                    r_total  <= '0;
                    r_state  <= ST_SUM;
                end
                ST_SUM: begin
                    if (r_rk != r_count) begin
                        r_rk <= r_rk + CW'(1);
                        r_rv <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        r_prod <= PROD_W'(17'({1'b0, r_prev[15:0]} + {1'b0, r_rdata[15:0]}))
                                * PROD_W'(32'(r_rdata[47:16] - r_prev[47:16]));
                        r_pv   <= r_hp;
                        r_prev <= r_rdata;
                        r_hp   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) r_total <= r_total + TW'(r_prod);
                    if (r_rk == r_count && !r_rv && !r_pv) r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (w_out_load) begin
                        r_out.impulse_pulse <= w_level && !r_flag;
                        r_out.impulse_level <= w_level;
                        r_out.window_sum    <= w_sum;
                        r_out.forced_drop   <= r_forced;
                        r_flag              <= w_level;
                        r_state             <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("ring count beyond depth");
    a_pulse_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!o_result.payload.impulse_pulse
                            || o_result.payload.impulse_level))
        else $error("impulse pulse without level");
    a_ring_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT) |-> (r_count != '0))
        else $error("result with empty ring");
    a_forced_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPEND) && (r_count == DEPTH_C) |=> (r_count == DEPTH_C))
        else $error("forced drop left the ring short");
endmodule

### sim/aiwd_impulse_checker.sv
// Checker for the accelerometer impulse window detector: watches the sample,
// result and register-write ports, predicts each result and compares it.
// Depends on aiwd_pkg and aiwd_stream_if.
module aiwd_impulse_checker
    import aiwd_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    aiwd_stream_if                i_sample,
    aiwd_stream_if                o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [21:0] win_us;
    logic [39:0] thresh;
    logic [14:0] g_counts;
    logic [31:0] hist_time [DEPTH];
    logic [15:0] hist_dev [DEPTH];
    int          hist_head;
    int          hist_count;
    logic        level_q;
    t_out_item   impulse_q [$];

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    task automatic predict_impulse(input t_in_item s);
        logic signed [63:0] ax;
        logic signed [63:0] ay;
        logic signed [63:0] az;
        logic [31:0] mag;
        logic [31:0] dev;
        logic [63:0] acc;
        logic [31:0] dt;
        int          a;
        int          b;
        t_out_item   r;
        ax = s.accel_x;
        ay = s.accel_y;
        az = s.accel_z;
        mag = int_sqrt(ax * ax + ay * ay + az * az);
        dev = (mag >= g_counts) ? mag - g_counts : g_counts - mag;
        r = '0;
        while (hist_count > 0 && 32'(s.time_us - hist_time[hist_head]) > win_us) begin
            hist_head = (hist_head + 1) % DEPTH;
            hist_count--;
        end
        if (hist_count >= DEPTH) begin
            hist_head = (hist_head + 1) % DEPTH;
            hist_count = DEPTH - 1;
            r.forced_drop = 1'b1;
        end
        hist_time[(hist_head + hist_count) % DEPTH] = s.time_us;
        hist_dev[(hist_head + hist_count) % DEPTH] = dev[15:0];
        hist_count++;
        acc = 0;
        for (int k = 0; k + 1 < hist_count; k++) begin
            a = (hist_head + k) % DEPTH;
            b = (hist_head + k + 1) % DEPTH;
            dt = hist_time[b] - hist_time[a];
            acc = acc + (64'(hist_dev[a]) + 64'(hist_dev[b])) * 64'(dt);
            if (acc > 64'(SUM_MAX)) acc = 64'(SUM_MAX);
        end
        r.window_sum = acc[SUM_W-1:0];
        r.impulse_level = (acc >= 64'(thresh));
        r.impulse_pulse = r.impulse_level && !level_q;
        level_q = r.impulse_level;
        impulse_q = {impulse_q, r};
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            win_us = WINDOW_US_RST;
            thresh = THRESHOLD_RST;
            g_counts = ONE_G_RST;
            hist_head = 0;
            hist_count = 0;
            level_q = 1'b0;
            impulse_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_US: win_us = i_cfg_data[21:0];
                    CFG_THRESHOLD: thresh = i_cfg_data[39:0];
                    CFG_ONE_G:     g_counts = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready) predict_impulse(i_sample.payload);
            if (o_result.valid && o_result.ready) begin
                if (impulse_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result %p", o_result.payload);
                end else begin
                    want = impulse_q.pop_front();
                    if (o_result.payload !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, o_result.payload);
                    end
                end
            end
        end
        o_pending = impulse_q.size();
    end

endmodule

### sim/accel_impulse_window_detector_core_tb.sv
// Testbench top for the accelerometer impulse window detector: drives samples
// and register writes through idle phases; checking lives in aiwd_impulse_checker.
// Depends on aiwd_pkg, aiwd_stream_if, the core and the checker.
module accel_impulse_window_detector_core_tb;
    import aiwd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_WAIT   = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    logic [31:0]           clock_us = 0;

    aiwd_stream_if #(.t_payload(t_in_item))  sample_ch ();
    aiwd_stream_if #(.t_payload(t_out_item)) result_ch ();

    accel_impulse_window_detector_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (sample_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    aiwd_impulse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (sample_ch),
        .o_result     (result_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        result_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_sample(input t_in_item s);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.payload <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        // drop valid after the transaction, before the next sample
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random axis: mostly near one g on z, sometimes full scale.
    function automatic t_in_item make_sample(input int step_us);
        t_in_item s;
        s.accel_x = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4000)) - 16'sd2000;
        s.accel_y = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4000)) - 16'sd2000;
        s.accel_z = $urandom_range(9) == 0 ? 16'($urandom)
                                           : 16'($urandom_range(16000)) + 16'sd200;
        s.time_us = $urandom_range(49) == 0 ? $urandom : clock_us + step_us;
        clock_us = s.time_us;
        return s;
    endfunction

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_in_item s;
        int step;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: axis extremes, zero vector, timestamp wrap, out-of-order time.
        s = '{16'sh8000, 16'sh8000, 16'sh8000, 32'd0};            send_sample(s);
        s = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 32'd1000};         send_sample(s);
        s = '{16'sh0000, 16'sh0000, 16'sh0000, 32'd2000};         send_sample(s);
        s = '{16'sh0000, 16'sh0000, 16'sd8192, 32'd2000};         send_sample(s);
        s = '{16'sh7fff, 16'sh8000, 16'sh0001, 32'hFFFF_FF00};    send_sample(s);
        s = '{16'sh0001, 16'shFFFF, 16'sh5555, 32'h0000_0100};    send_sample(s);
        s = '{16'shAAAA, 16'sh5555, 16'shAAAA, 32'h0000_0080};    send_sample(s);
        s = '{16'sh0000, 16'sh0000, 16'sd8192, 32'hFFFF_FFFF};    send_sample(s);
        drain();

        // Ring overflow with a huge window, tiny one_g and zero threshold.
        write_reg(CFG_WINDOW_US, 40'h3F_FFFF);
        write_reg(CFG_THRESHOLD, 40'd0);
        write_reg(CFG_ONE_G, 40'd0);
        write_reg(2'd3, 40'hFF_FFFF_FFFF);
        for (int i = 0; i < 70; i++) begin
            s = '{16'sh7fff, 16'sh8000, 16'sh7fff, 32'(i * 60000)};
            send_sample(s);
        end
        drain();

        // Window zero, maximal threshold and one_g.
        write_reg(CFG_WINDOW_US, 40'd0);
        write_reg(CFG_THRESHOLD, 40'hFF_FFFF_FFFF);
        write_reg(CFG_ONE_G, 40'h7FFF);
        for (int i = 0; i < 6; i++) begin
            s = '{16'sh1234, 16'shEDCB, 16'sh7fff, 32'(500 * (i / 2))};
            send_sample(s);
        end
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                3: begin send_idle_pct = 33; recv_stall_pct = 33; end
                default: begin send_idle_pct = $urandom_range(50); recv_stall_pct = $urandom_range(50); end
            endcase
            write_reg(CFG_WINDOW_US, ph == 5 ? 40'd1 : 40'($urandom_range(400000, 1000)));
            write_reg(CFG_THRESHOLD, ph == 4 ? 40'h0 : 40'($urandom_range(2000000000, 1000000)));
            write_reg(CFG_ONE_G, ph == 0 ? 40'd1 : (ph == 1 ? 40'd32767 : 40'd8192));
            step = (ph == 5) ? 1 : $urandom_range(8000, 1000);
            for (int i = 0; i < 250; i++) begin
                send_sample(make_sample($urandom_range(2 * step)));
                // Hold off until the pipe is empty once per phase.
                if (i == 120) while (pending != 0) @(posedge i_clk);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
